@@ src/sto_pkg.sv @@
// shared constants for the sphere-triangle overlap test
package sto_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int CSR_INDEX_BITS       = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTRE_X  = 2'd0,
      CSR_CENTRE_Y  = 2'd1,
      CSR_CENTRE_Z  = 2'd2,
      CSR_RADIUS    = 2'd3
   } csr_index_type;

endpackage

@@ src/sto_plane.sv @@
// plane distance, reject, circle centre and squared circle radius (four stages)
module sto_plane #(
   parameter int CB = 16,
   parameter int NF = 14,
   localparam int NW = NF + 2,
   localparam int DW = CB + 1,
   localparam int P1W = NW + DW,
   localparam int DFW = P1W + 2,
   localparam int DTW = DFW - NF,
   localparam int DNW = DTW + NW,
   localparam int CW = DNW - NF + 1,
   localparam int RRW = 2 * CB + 2,
   localparam int DDW = 2 * DTW,
   localparam int RSQW = DDW + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [CB-1:0]   v_in [3][3],
   input  logic signed [NW-1:0]   n_in [3],
   input  logic signed [CB-1:0]   ctr [3],
   input  logic        [CB-2:0]   rad,
   output logic                   out_valid,
   output logic                   out_reject,
   output logic signed [CB-1:0]   v_out [3][3],
   output logic signed [NW-1:0]   n_out [3],
   output logic signed [CW-1:0]   c_out [3],
   output logic signed [RSQW-1:0] rsq_out
);
   logic                   vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic signed [CB-1:0]   v1_ff [3][3], v2_ff [3][3], v3_ff [3][3], v4_ff [3][3];
   logic signed [NW-1:0]   n1_ff [3], n2_ff [3], n3_ff [3], n4_ff [3];
   logic signed [P1W-1:0]  p1_in [3], p1_ff [3];
   logic signed [DFW-1:0]  dfull;
   logic signed [DFW:0]    rlim;
   logic signed [CB:0]     rads;
   logic                   rej2_in, rej2_ff, rej3_ff, rej4_ff;
   logic signed [DTW-1:0]  d2_in, d2_ff;
   logic signed [DNW-1:0]  dn3_in [3], dn3_ff [3];
   logic signed [DDW-1:0]  dd3_ff;
   logic signed [RRW-1:0]  rr3_ff;
   logic signed [CW-1:0]   c4_in [3], c4_ff [3];
   logic signed [RSQW-1:0] rsq4_ff;

   assign rads = {1'b0, rad};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = P1W'(n_in[i]) * (P1W'(v_in[0][i]) - P1W'(ctr[i]));
      end
      dfull = DFW'(p1_ff[0]) + DFW'(p1_ff[1]) + DFW'(p1_ff[2]);
      rlim = (DFW+1)'(rads) <<< NF;
      rej2_in = ((DFW+1)'(dfull) > rlim) || ((DFW+1)'(dfull) < -rlim);
      d2_in = DTW'(dfull >>> NF);
      for (int i = 0; i < 3; i++) begin
         dn3_in[i] = DNW'(d2_ff) * DNW'(n2_ff[i]);
         c4_in[i] = CW'(ctr[i]) + CW'(dn3_ff[i] >>> NF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff <= v_in;
         n1_ff <= n_in;
         p1_ff <= p1_in;
         v2_ff <= v1_ff;
         n2_ff <= n1_ff;
         rej2_ff <= rej2_in;
         d2_ff <= d2_in;
         v3_ff <= v2_ff;
         n3_ff <= n2_ff;
         rej3_ff <= rej2_ff;
         dn3_ff <= dn3_in;
         dd3_ff <= DDW'(d2_ff) * DDW'(d2_ff);
         rr3_ff <= RRW'(rads) * RRW'(rads);
         v4_ff <= v3_ff;
         n4_ff <= n3_ff;
         rej4_ff <= rej3_ff;
         c4_ff <= c4_in;
         rsq4_ff <= RSQW'(rr3_ff) - RSQW'(dd3_ff);
      end
   end

   assign out_valid  = vld4_ff;
   assign out_reject = rej4_ff;
   assign v_out      = v4_ff;
   assign n_out      = n4_ff;
   assign c_out      = c4_ff;
   assign rsq_out    = rsq4_ff;
endmodule

@@ src/sto_geom.sv @@
// offsets, edges, squared distances, edge normals and projections (three stages)
module sto_geom #(
   parameter int CB = 16,
   parameter int NF = 14,
   localparam int NW = NF + 2,
   localparam int DTW = CB + NW + 3 - NF,
   localparam int CW = DTW + NW - NF + 1,
   localparam int RSQW = 2 * DTW + 1,
   localparam int CVW = CW + 1,
   localparam int EW = CB + 1,
   localparam int SQW = 2 * CVW,
   localparam int MAGW = SQW + 2,
   localparam int ENPW = EW + NW,
   localparam int ENW = ENPW + 1,
   localparam int DPPW = CVW + EW,
   localparam int DPW = DPPW + 2,
   localparam int MSPW = 2 * EW,
   localparam int MSW = MSPW + 2,
   localparam int CMW = MAGW + RSQW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic                   in_reject,
   input  logic signed [CB-1:0]   v_in [3][3],
   input  logic signed [NW-1:0]   n_in [3],
   input  logic signed [CW-1:0]   c_in [3],
   input  logic signed [RSQW-1:0] rsq_in,
   output logic                   out_valid,
   output logic                   out_reject,
   output logic                   out_vhit,
   output logic signed [CVW-1:0]  cv_out [3][3],
   output logic signed [RSQW-1:0] rsq_out,
   output logic signed [MAGW-1:0] mag_out [3],
   output logic signed [ENW-1:0]  en_out [3][3],
   output logic signed [DPW-1:0]  dp_out [3],
   output logic signed [MSW-1:0]  ms_out [3]
);
   logic                   vld5_ff, vld6_ff, vld7_ff;
   logic                   rej5_ff, rej6_ff, rej7_ff, vhit7_in, vhit7_ff;
   logic signed [RSQW-1:0] rsq5_ff, rsq6_ff, rsq7_ff;
   logic signed [NW-1:0]   n5_ff [3];
   logic signed [CVW-1:0]  cv5_in [3][3], cv5_ff [3][3], cv6_ff [3][3], cv7_ff [3][3];
   logic signed [EW-1:0]   e5_in [3][3], e5_ff [3][3];
   logic signed [SQW-1:0]  sq6_in [3][3], sq6_ff [3][3];
   logic signed [ENPW-1:0] t6_in [3][6], t6_ff [3][6];
   logic signed [DPPW-1:0] dpt6_in [3][3], dpt6_ff [3][3];
   logic signed [MSPW-1:0] mst6_in [3][3], mst6_ff [3][3];
   logic signed [MAGW-1:0] mag7_in [3], mag7_ff [3];
   logic signed [ENW-1:0]  en7_in [3][3], en7_ff [3][3];
   logic signed [DPW-1:0]  dp7_in [3], dp7_ff [3];
   logic signed [MSW-1:0]  ms7_in [3], ms7_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            cv5_in[k][i] = CVW'(c_in[i]) - CVW'(v_in[k][i]);
            e5_in[k][i]  = EW'(v_in[k][i]) - EW'(v_in[(k + 1) % 3][i]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            sq6_in[k][i]  = SQW'(cv5_ff[k][i]) * SQW'(cv5_ff[k][i]);
            dpt6_in[k][i] = DPPW'(cv5_ff[(k + 1) % 3][i]) * DPPW'(e5_ff[k][i]);
            mst6_in[k][i] = MSPW'(e5_ff[k][i]) * MSPW'(e5_ff[k][i]);
         end
         t6_in[k][0] = ENPW'(e5_ff[k][1]) * ENPW'(n5_ff[2]);
         t6_in[k][1] = ENPW'(e5_ff[k][2]) * ENPW'(n5_ff[1]);
         t6_in[k][2] = ENPW'(e5_ff[k][2]) * ENPW'(n5_ff[0]);
         t6_in[k][3] = ENPW'(e5_ff[k][0]) * ENPW'(n5_ff[2]);
         t6_in[k][4] = ENPW'(e5_ff[k][0]) * ENPW'(n5_ff[1]);
         t6_in[k][5] = ENPW'(e5_ff[k][1]) * ENPW'(n5_ff[0]);
      end
      vhit7_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         mag7_in[k] = MAGW'(sq6_ff[k][0]) + MAGW'(sq6_ff[k][1]) + MAGW'(sq6_ff[k][2]);
         dp7_in[k]  = DPW'(dpt6_ff[k][0]) + DPW'(dpt6_ff[k][1]) + DPW'(dpt6_ff[k][2]);
         ms7_in[k]  = MSW'(mst6_ff[k][0]) + MSW'(mst6_ff[k][1]) + MSW'(mst6_ff[k][2]);
         en7_in[k][0] = ENW'(t6_ff[k][0]) - ENW'(t6_ff[k][1]);
         en7_in[k][1] = ENW'(t6_ff[k][2]) - ENW'(t6_ff[k][3]);
         en7_in[k][2] = ENW'(t6_ff[k][4]) - ENW'(t6_ff[k][5]);
         if (CMW'(mag7_in[k]) < CMW'(rsq6_ff)) begin
            vhit7_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else if (adv) begin
         vld5_ff <= in_valid;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rej5_ff  <= in_reject;
         rsq5_ff  <= rsq_in;
         n5_ff    <= n_in;
         cv5_ff   <= cv5_in;
         e5_ff    <= e5_in;
         rej6_ff  <= rej5_ff;
         rsq6_ff  <= rsq5_ff;
         cv6_ff   <= cv5_ff;
         sq6_ff   <= sq6_in;
         t6_ff    <= t6_in;
         dpt6_ff  <= dpt6_in;
         mst6_ff  <= mst6_in;
         rej7_ff  <= rej6_ff;
         rsq7_ff  <= rsq6_ff;
         cv7_ff   <= cv6_ff;
         vhit7_ff <= vhit7_in;
         mag7_ff  <= mag7_in;
         en7_ff   <= en7_in;
         dp7_ff   <= dp7_in;
         ms7_ff   <= ms7_in;
      end
   end

   assign out_valid  = vld7_ff;
   assign out_reject = rej7_ff;
   assign out_vhit   = vhit7_ff;
   assign cv_out     = cv7_ff;
   assign rsq_out    = rsq7_ff;
   assign mag_out    = mag7_ff;
   assign en_out     = en7_ff;
   assign dp_out     = dp7_ff;
   assign ms_out     = ms7_ff;
endmodule

@@ src/sto_decide.sv @@
// inside-edge signs, segment reach and the final hit flag (three stages)
module sto_decide #(
   parameter int CB = 16,
   parameter int NF = 14,
   localparam int NW = NF + 2,
   localparam int DTW = CB + NW + 3 - NF,
   localparam int CW = DTW + NW - NF + 1,
   localparam int RSQW = 2 * DTW + 1,
   localparam int CVW = CW + 1,
   localparam int EW = CB + 1,
   localparam int MAGW = 2 * CVW + 2,
   localparam int ENW = EW + NW + 1,
   localparam int DPW = CVW + EW + 2,
   localparam int MSW = 2 * EW + 2,
   localparam int SPW = CVW + ENW,
   localparam int SW = SPW + 2,
   localparam int MSU = MSW - 1,
   localparam int MSL = (MSU + 1) / 2,
   localparam int MSH = MSU - MSL,
   localparam int MGU = MAGW - 1,
   localparam int MGL = (MGU + 1) / 2,
   localparam int MGH = MGU - MGL,
   localparam int RSU = RSQW - 1,
   localparam int RSL = (RSU + 1) / 2,
   localparam int RSH = RSU - RSL,
   localparam int DPU = DPW - 1,
   localparam int DPL = (DPU + 1) / 2,
   localparam int DPH = DPU - DPL,
   localparam int LPW = MSL + MGL,
   localparam int RPW = MSL + RSL,
   localparam int DQW = 2 * DPL,
   localparam int WU = MSU + MGU + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic                   in_reject,
   input  logic                   in_vhit,
   input  logic signed [CVW-1:0]  cv_in [3][3],
   input  logic signed [RSQW-1:0] rsq_in,
   input  logic signed [MAGW-1:0] mag_in [3],
   input  logic signed [ENW-1:0]  en_in [3][3],
   input  logic signed [DPW-1:0]  dp_in [3],
   input  logic signed [MSW-1:0]  ms_in [3],
   output logic                   out_valid,
   output logic                   out_hit
);
   logic                  vld8_ff, vld9_ff, vld10_ff;
   logic                  rej8_ff, rej9_ff, vhit8_ff, vhit9_ff;
   logic                  all_in9_in, all_in9_ff, hit10_in, hit10_ff;
   logic signed [SPW-1:0] sp8_in [3][3], sp8_ff [3][3];
   logic                  ok8_in [3], ok8_ff [3], ok9_ff [3];
   logic [MSL-1:0]        ms_lo [3];
   logic [MSH-1:0]        ms_hi [3];
   logic [MGL-1:0]        mag_lo [3];
   logic [MGH-1:0]        mag_hi [3];
   logic [RSL-1:0]        rsq_lo;
   logic [RSH-1:0]        rsq_hi;
   logic [DPL-1:0]        dp_lo [3];
   logic [DPH-1:0]        dp_hi [3];
   logic [LPW-1:0]        lp8_ff [3][4];
   logic [RPW-1:0]        rp8_ff [3][4];
   logic [DQW-1:0]        dq8_ff [3][3];
   logic [WU-1:0]         lhs9_in [3], lhs9_ff [3], rhs9_in [3], rhs9_ff [3];
   logic signed [SW-1:0]  s9;
   logic                  edge_hit;

   always_comb begin
      rsq_lo = rsq_in[RSL-1:0];
      rsq_hi = rsq_in[RSU-1:RSL];
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            sp8_in[k][i] = SPW'(cv_in[(k + 1) % 3][i]) * SPW'(en_in[k][i]);
         end
         ok8_in[k] = (ms_in[k] > MSW'(0)) && (dp_in[k] >= DPW'(0))
                   && (MSW'(dp_in[k]) <= ms_in[k]);
         ms_lo[k]  = ms_in[k][MSL-1:0];
         ms_hi[k]  = ms_in[k][MSU-1:MSL];
         mag_lo[k] = mag_in[(k + 1) % 3][MGL-1:0];
         mag_hi[k] = mag_in[(k + 1) % 3][MGU-1:MGL];
         dp_lo[k]  = dp_in[k][DPL-1:0];
         dp_hi[k]  = dp_in[k][DPU-1:DPL];
      end
      all_in9_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         s9 = SW'(sp8_ff[k][0]) + SW'(sp8_ff[k][1]) + SW'(sp8_ff[k][2]);
         if (s9 < SW'(0)) begin
            all_in9_in = 1'b0;
         end
         lhs9_in[k] = WU'(lp8_ff[k][0]) + (WU'(lp8_ff[k][1]) << MGL)
                    + (WU'(lp8_ff[k][2]) << MSL) + (WU'(lp8_ff[k][3]) << (MSL + MGL));
         rhs9_in[k] = WU'(rp8_ff[k][0]) + (WU'(rp8_ff[k][1]) << RSL)
                    + (WU'(rp8_ff[k][2]) << MSL) + (WU'(rp8_ff[k][3]) << (MSL + RSL))
                    + WU'(dq8_ff[k][0]) + (WU'(dq8_ff[k][1]) << (DPL + 1))
                    + (WU'(dq8_ff[k][2]) << (2 * DPL));
      end
      edge_hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (ok9_ff[k] && (lhs9_ff[k] <= rhs9_ff[k])) begin
            edge_hit = 1'b1;
         end
      end
      hit10_in = !rej9_ff && (vhit9_ff || all_in9_ff || edge_hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld8_ff  <= 1'b0;
         vld9_ff  <= 1'b0;
         vld10_ff <= 1'b0;
      end else if (adv) begin
         vld8_ff  <= in_valid;
         vld9_ff  <= vld8_ff;
         vld10_ff <= vld9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rej8_ff  <= in_reject;
         vhit8_ff <= in_vhit;
         sp8_ff   <= sp8_in;
         ok8_ff   <= ok8_in;
         for (int k = 0; k < 3; k++) begin
            lp8_ff[k][0] <= LPW'(ms_lo[k]) * LPW'(mag_lo[k]);
            lp8_ff[k][1] <= LPW'(ms_lo[k]) * LPW'(mag_hi[k]);
            lp8_ff[k][2] <= LPW'(ms_hi[k]) * LPW'(mag_lo[k]);
            lp8_ff[k][3] <= LPW'(ms_hi[k]) * LPW'(mag_hi[k]);
            rp8_ff[k][0] <= RPW'(ms_lo[k]) * RPW'(rsq_lo);
            rp8_ff[k][1] <= RPW'(ms_lo[k]) * RPW'(rsq_hi);
            rp8_ff[k][2] <= RPW'(ms_hi[k]) * RPW'(rsq_lo);
            rp8_ff[k][3] <= RPW'(ms_hi[k]) * RPW'(rsq_hi);
            dq8_ff[k][0] <= DQW'(dp_lo[k]) * DQW'(dp_lo[k]);
            dq8_ff[k][1] <= DQW'(dp_lo[k]) * DQW'(dp_hi[k]);
            dq8_ff[k][2] <= DQW'(dp_hi[k]) * DQW'(dp_hi[k]);
         end
         rej9_ff    <= rej8_ff;
         vhit9_ff   <= vhit8_ff;
         ok9_ff     <= ok8_ff;
         all_in9_ff <= all_in9_in;
         lhs9_ff    <= lhs9_in;
         rhs9_ff    <= rhs9_in;
         hit10_ff   <= hit10_in;
      end
   end

   assign out_valid = vld10_ff;
   assign out_hit   = hit10_ff;
endmodule

@@ src/sphere_triangle_overlap_test_top.sv @@
// top level of the sphere-triangle overlap test
// Tests one triangle per cycle against the sphere held in the csr registers and
// returns a hit flag for each input beat that is taken. The ten-stage
// pipeline moves as one: it advances whenever the result register is empty or
// being read, so a stalled result holds every stage and back-pressure reaches
// req_tready in the same cycle. Write the csr registers only while no beat is in
// flight; csr_index has no value beyond the radius register.
module sphere_triangle_overlap_test_top #(
   parameter int COORD_BITS       = sto_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = sto_pkg::NORMAL_FRAC_BITS_DEF,
   localparam int NW   = NORMAL_FRAC_BITS + 2,
   localparam int REQW = ((9 * COORD_BITS + 3 * NW + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z normal_x normal_y normal_z
   input  logic [REQW-1:0]                    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit
   output logic [7:0]                         rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sto_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]              csr_data
);
   import sto_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int NF   = NORMAL_FRAC_BITS;
   localparam int DTW  = CB + NW + 3 - NF;
   localparam int CW   = DTW + NW - NF + 1;
   localparam int RSQW = 2 * DTW + 1;
   localparam int CVW  = CW + 1;
   localparam int EW   = CB + 1;
   localparam int MAGW = 2 * CVW + 2;
   localparam int ENW  = EW + NW + 1;
   localparam int DPW  = CVW + EW + 2;
   localparam int MSW  = 2 * EW + 2;

   logic signed [CB-1:0]   ctr_ff [3];
   logic        [CB-2:0]   rad_ff;
   logic                   adv;
   logic signed [CB-1:0]   v_in [3][3];
   logic signed [NW-1:0]   n_in [3];
   logic                   pl_valid, pl_reject;
   logic signed [CB-1:0]   pl_v [3][3];
   logic signed [NW-1:0]   pl_n [3];
   logic signed [CW-1:0]   pl_c [3];
   logic signed [RSQW-1:0] pl_rsq;
   logic                   gm_valid, gm_reject, gm_vhit;
   logic signed [CVW-1:0]  gm_cv [3][3];
   logic signed [RSQW-1:0] gm_rsq;
   logic signed [MAGW-1:0] gm_mag [3];
   logic signed [ENW-1:0]  gm_en [3][3];
   logic signed [DPW-1:0]  gm_dp [3];
   logic signed [MSW-1:0]  gm_ms [3];
   logic                   hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff[0] <= '0;
         ctr_ff[1] <= '0;
         ctr_ff[2] <= '0;
         rad_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTRE_X: ctr_ff[0] <= csr_data;
            CSR_CENTRE_Y: ctr_ff[1] <= csr_data;
            CSR_CENTRE_Z: ctr_ff[2] <= csr_data;
            CSR_RADIUS:   rad_ff    <= csr_data[CB-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            v_in[k][i] = req_tdata[(k * 3 + i) * CB +: CB];
         end
      end
      for (int i = 0; i < 3; i++) begin
         n_in[i] = req_tdata[9 * CB + i * NW +: NW];
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   sto_plane #(.CB(CB), .NF(NF)) u_plane (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid), .v_in(v_in), .n_in(n_in),
      .ctr(ctr_ff), .rad(rad_ff),
      .out_valid(pl_valid), .out_reject(pl_reject),
      .v_out(pl_v), .n_out(pl_n), .c_out(pl_c), .rsq_out(pl_rsq)
   );

   sto_geom #(.CB(CB), .NF(NF)) u_geom (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(pl_valid), .in_reject(pl_reject),
      .v_in(pl_v), .n_in(pl_n), .c_in(pl_c), .rsq_in(pl_rsq),
      .out_valid(gm_valid), .out_reject(gm_reject), .out_vhit(gm_vhit),
      .cv_out(gm_cv), .rsq_out(gm_rsq), .mag_out(gm_mag),
      .en_out(gm_en), .dp_out(gm_dp), .ms_out(gm_ms)
   );

   sto_decide #(.CB(CB), .NF(NF)) u_decide (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(gm_valid), .in_reject(gm_reject), .in_vhit(gm_vhit),
      .cv_in(gm_cv), .rsq_in(gm_rsq), .mag_in(gm_mag),
      .en_in(gm_en), .dp_in(gm_dp), .ms_in(gm_ms),
      .out_valid(rsp_tvalid), .out_hit(hit)
   );

   assign rsp_tdata = {7'd0, hit};

`ifndef SYNTHESIS
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty result register");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");
`endif
endmodule

@@ verif/testbench.sv @@
// testbench for the sphere-triangle overlap test: directed and random triangles
module testbench;
   import sto_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB   = COORD_BITS_DEF;
   localparam int FB   = NORMAL_FRAC_BITS_DEF;
   localparam int NW   = FB + 2;
   localparam int REQW = ((9 * CB + 3 * NW + 7) / 8) * 8;

   typedef struct {
      logic signed [CB-1:0] v [3][3];
      logic signed [NW-1:0] n [3];
   } triangle_type;

   class hit_scoreboard;
      logic signed [CB-1:0] centre [3];
      logic [CB-2:0]        radius;
      bit                   hit_queue [$];
      int                   errors;

      function automatic longint floor_shift(longint x);
         return x >>> FB;
      endfunction

      function automatic bit overlap(triangle_type t);
         longint v [3][3], n [3], ctr [3], c [3], cv [3][3], e [3][3], mag [3];
         longint r, dfull, d, rsq, adf, nx, ny, nz, ms, dp;
         logic signed [127:0] s, lhs, rhs;
         bit all_in;
         int j;
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) v[k][i] = t.v[k][i];
         for (int i = 0; i < 3; i++) begin
            n[i] = t.n[i];
            ctr[i] = centre[i];
         end
         r = radius;
         dfull = 0;
         for (int i = 0; i < 3; i++) dfull += n[i] * (v[0][i] - ctr[i]);
         adf = dfull < 0 ? -dfull : dfull;
         if (adf > (r << FB)) return 0;
         d = floor_shift(dfull);
         for (int i = 0; i < 3; i++) c[i] = ctr[i] + floor_shift(d * n[i]);
         rsq = r * r - d * d;
         for (int k = 0; k < 3; k++) begin
            mag[k] = 0;
            for (int i = 0; i < 3; i++) begin
               cv[k][i] = c[i] - v[k][i];
               mag[k] += cv[k][i] * cv[k][i];
            end
            if (mag[k] < rsq) return 1;
         end
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) e[k][i] = v[k][i] - v[(k + 1) % 3][i];
         all_in = 1;
         for (int k = 0; k < 3; k++) begin
            j = (k + 1) % 3;
            nx = e[k][1] * n[2] - e[k][2] * n[1];
            ny = e[k][2] * n[0] - e[k][0] * n[2];
            nz = e[k][0] * n[1] - e[k][1] * n[0];
            s = 128'(signed'(cv[j][0])) * nx + 128'(signed'(cv[j][1])) * ny
                + 128'(signed'(cv[j][2])) * nz;
            if (s < 0) all_in = 0;
         end
         if (all_in) return 1;
         for (int k = 0; k < 3; k++) begin
            j = (k + 1) % 3;
            ms = 0;
            dp = 0;
            for (int i = 0; i < 3; i++) begin
               ms += e[k][i] * e[k][i];
               dp += cv[j][i] * e[k][i];
            end
            if (ms > 0 && dp >= 0 && dp <= ms) begin
               lhs = 128'(signed'(ms)) * mag[j];
               rhs = 128'(signed'(ms)) * rsq + 128'(signed'(dp)) * dp;
               if (lhs <= rhs) return 1;
            end
         end
         return 0;
      endfunction

      function void note_triangle(triangle_type t);
         hit_queue.push_back(overlap(t));
      endfunction

      function void check_hit(logic [7:0] got);
         bit want;
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = hit_queue.pop_front();
         if (got !== {7'd0, want}) begin
            $display("%0t: hit mismatch, expected %0d, actual %h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [REQW-1:0] req_tdata = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [7:0] rsp_tdata;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CENTRE_X;
   logic [CB-1:0] csr_data = '0;
   int send_idle = 0, recv_stall = 0;
   hit_scoreboard sb = new();

   always #5 clock = ~clock;

   sphere_triangle_overlap_test_top DUT (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_triangle(pack_out(req_tdata));
         if (rsp_tvalid && rsp_tready) sb.check_hit(rsp_tdata);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic triangle_type pack_out(logic [REQW-1:0] bits);
      triangle_type t;
      for (int f = 0; f < 9; f++) t.v[f / 3][f % 3] = bits[f * CB +: CB];
      for (int i = 0; i < 3; i++) t.n[i] = bits[9 * CB + i * NW +: NW];
      return t;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [CB-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RADIUS) sb.radius = val[CB-2:0];
      else sb.centre[idx] = val;
   endtask

   task automatic set_sphere(logic [CB-1:0] x, y, z, logic [CB-2:0] r);
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.hit_queue.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      write_csr(CSR_CENTRE_X, x);
      write_csr(CSR_CENTRE_Y, y);
      write_csr(CSR_CENTRE_Z, z);
      write_csr(CSR_RADIUS, {1'b0, r});
      csr_valid <= 0;
   endtask

   task automatic send_triangle(triangle_type t);
      logic [REQW-1:0] bits;
      bits = '0;
      for (int f = 0; f < 9; f++) bits[f * CB +: CB] = t.v[f / 3][f % 3];
      for (int i = 0; i < 3; i++) bits[9 * CB + i * NW +: NW] = t.n[i];
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= bits;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic signed [NW-1:0] rand_normal();
      case ($urandom_range(3))
         0: return NW'(signed'($urandom_range(32768)) - 16384);
         1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         2: return '0;
         default: return NW'($urandom);
      endcase
   endfunction

   // triangles near the sphere, or anywhere when spread is zero, so every test stage gets reached
   function automatic triangle_type rand_triangle(int spread);
      triangle_type t;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            if (spread == 0) t.v[k][i] = CB'($urandom);
            else t.v[k][i] = CB'(int'(sb.centre[i]) + int'($urandom_range(2 * spread))
                                 - spread);
      for (int i = 0; i < 3; i++) t.n[i] = rand_normal();
      return t;
   endfunction

   function automatic triangle_type flat_triangle(logic signed [CB-1:0] a, b, c,
                                                  logic signed [NW-1:0] nx, ny, nz);
      triangle_type t;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) t.v[k][i] = (i == k) ? a : (i == 2 ? c : b);
      t.n[0] = nx;
      t.n[1] = ny;
      t.n[2] = nz;
      return t;
   endfunction

   task automatic random_phase(int count);
      int spread;
      for (int i = 0; i < count; i++) begin
         spread = $urandom_range(9) == 0 ? 0 : (1 << $urandom_range(12));
         send_triangle(rand_triangle(spread));
      end
   endtask

   initial begin
      triangle_type t;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset sphere, then directed corners
      send_triangle(flat_triangle(0, 0, 0, 0, 0, 0));
      set_sphere(0, 0, 0, 100);
      send_triangle(flat_triangle(50, 0, 0, 0, 0, 16384));
      send_triangle(flat_triangle(500, -500, 0, 0, 0, 16384));
      send_triangle(flat_triangle(500, -500, 101, 0, 0, 16384));
      send_triangle(flat_triangle(500, -500, -100, 0, 0, -16384));
      send_triangle(flat_triangle(200, 0, 0, 0, 0, 0));
      send_triangle(flat_triangle(32767, -32768, 32767, 16384, 16384, 16384));
      send_triangle(flat_triangle(-32768, 32767, -32768, -32768, 32767, -1));
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) t.v[k][i] = 7;
      t.n[0] = 0;
      t.n[1] = 0;
      t.n[2] = 16384;
      send_triangle(t);
      t.v[1][0] = 200;
      t.v[2][0] = 200;
      t.v[0][0] = -200;
      t.v[0][1] = 100;
      t.v[1][1] = 100;
      t.v[2][1] = 300;
      send_triangle(t);
      t.v[0][1] = 0;
      t.v[1][1] = 0;
      send_triangle(t);
      set_sphere(16'h7fff, 16'h8000, 16'h7fff, 15'h7fff);
      send_triangle(flat_triangle(-32768, 32767, -32768, 16384, -16384, 16384));
      send_triangle(flat_triangle(32767, -32768, 32767, 0, 0, 16384));
      send_triangle(flat_triangle(0, 0, 0, -16384, 0, 0));
      set_sphere(16'h8000, 16'h7fff, 16'h8000, 0);
      send_triangle(flat_triangle(-32768, 32767, -32768, 0, 16384, 0));
      send_triangle(flat_triangle(-32768, 32767, -32768, 0, 0, 0));
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 35; recv_stall = 35; end
         endcase
         if (ph == 4) set_sphere(0, 0, 0, 15'h7fff);
         else set_sphere(CB'($urandom), CB'($urandom), CB'($urandom),
                         ph == 7 ? 15'd0 : (CB - 1)'($urandom_range(1 << $urandom_range(14))));
         random_phase(230);
      end
      send_idle = 0;
      recv_stall = 0;
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.hit_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
